>>> hw/rtl/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// i2cseq_pkg
// Types, codes and constants shared by the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  localparam int MaxBytes = 255;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2
  } req_code_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RACK  = 3'd3,
    CMD_RNACK = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_BUSY = 2'd0,
    OUT_DONE = 2'd1,
    OUT_FAIL = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd1,
    PH_ADDR    = 3'd2,
    PH_WDATA   = 3'd3,
    PH_RX_ACK  = 3'd4,
    PH_RX_NACK = 3'd5
  } phase_t;

  localparam logic [7:0] StatusMask    = 8'hF8;
  localparam logic [7:0] StStart       = 8'h08;
  localparam logic [7:0] StRepStart    = 8'h10;
  localparam logic [7:0] StAddrAckWr   = 8'h18;
  localparam logic [7:0] StAddrAckRd   = 8'h40;
  localparam logic [7:0] StDataAckWr   = 8'h28;
  localparam logic [7:0] StDataAckRd   = 8'h50;
  localparam logic [7:0] StDataNackRd  = 8'h58;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] slave_address;
    logic [7:0] byte_count;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
  } req_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] tx_value;
    logic       rx_valid;
    logic [7:0] rx_data;
    outcome_t   outcome;
    logic [7:0] error_status;
  } rsp_t;

  typedef struct packed {
    phase_t     phase;
    logic       reading;
    logic [6:0] target_address;
    logic [7:0] bytes_left;
  } seq_state_t;

endpackage

>>> hw/rtl/i2cseq_req_if.sv
// ----------------------------------------------------------------------------
// i2cseq_req_if
// Request channel: begin requests and bus step events.
// ----------------------------------------------------------------------------
interface i2cseq_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] slave_address;
  logic [7:0] byte_count;
  logic [7:0] bus_status;
  logic [7:0] rx_byte;
  logic [7:0] tx_byte;

  modport source (
    output valid, req_type, slave_address, byte_count, bus_status, rx_byte, tx_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, slave_address, byte_count, bus_status, rx_byte, tx_byte,
    output ready
  );
endinterface

>>> hw/rtl/i2cseq_rsp_if.sv
// ----------------------------------------------------------------------------
// i2cseq_rsp_if
// Result channel: next bus command, received data and transaction outcome.
// ----------------------------------------------------------------------------
interface i2cseq_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_value;
  logic       rx_valid;
  logic [7:0] rx_data;
  logic [1:0] outcome;
  logic [7:0] error_status;

  modport source (
    output valid, command, tx_value, rx_valid, rx_data, outcome, error_status,
    input  ready
  );
  modport sink (
    input  valid, command, tx_value, rx_valid, rx_data, outcome, error_status,
    output ready
  );
endinterface

>>> hw/rtl/i2c_master_transaction_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_core
// I2C master write/read transaction sequencer over a byte-level bus engine.
// ----------------------------------------------------------------------------
// Takes one request beat per cycle unless the result side stalls, and
// returns exactly one result beat for each: begin write/read requests
// answer with START, bus step events are checked against the expected
// status and answered with the next command (address, data, receive with
// ACK/NACK, STOP) or a failure carrying the masked status. A request
// register feeds the status check and state update, then a result
// register. The transaction state is updated as each beat leaves the
// request register, so back-to-back beats see the state their predecessor
// left. A stalled result register holds the request register and the input.
module i2c_master_transaction_sequencer_core (
  input logic           clk,
  input logic           rst_n,
  i2cseq_req_if.sink    in_ch,
  i2cseq_rsp_if.source  out_ch
);

  logic                   s1_valid_r;
  i2cseq_pkg::req_t       s1_req_r;
  i2cseq_pkg::seq_state_t state_r;
  i2cseq_pkg::seq_state_t state_nxt;
  i2cseq_pkg::rsp_t       rsp_nxt;
  logic                   out_valid_r;
  i2cseq_pkg::rsp_t       out_rsp_r;
  logic                   advance;
  logic                   in_ready;

  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || advance;

  i2cseq_step u_step (
    .req       (s1_req_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .rsp       (rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: i2cseq_pkg::PH_IDLE, reading: 1'b0,
                       target_address: 7'd0, bytes_left: 8'd0};
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance && s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_req_r <= '{req_type:      in_ch.req_type,
                    slave_address: in_ch.slave_address,
                    byte_count:    in_ch.byte_count,
                    bus_status:    in_ch.bus_status,
                    rx_byte:       in_ch.rx_byte,
                    tx_byte:       in_ch.tx_byte};
    end
    if (advance && s1_valid_r) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.command      = out_rsp_r.command;
  assign out_ch.tx_value     = out_rsp_r.tx_value;
  assign out_ch.rx_valid     = out_rsp_r.rx_valid;
  assign out_ch.rx_data      = out_rsp_r.rx_data;
  assign out_ch.outcome      = out_rsp_r.outcome;
  assign out_ch.error_status = out_rsp_r.error_status;

endmodule

>>> hw/rtl/i2cseq_step.sv
// ----------------------------------------------------------------------------
// i2cseq_step
// Status check and next-command decision for one request against the
// current transaction state.
// ----------------------------------------------------------------------------
module i2cseq_step (
  input  i2cseq_pkg::req_t       req,
  input  i2cseq_pkg::seq_state_t state,
  output i2cseq_pkg::seq_state_t state_nxt,
  output i2cseq_pkg::rsp_t       rsp
);

  logic [7:0] code;
  logic [8:0] cnt;
  logic       wr_advance;

  assign code = req.bus_status & i2cseq_pkg::StatusMask;

  always_comb begin
    state_nxt  = state;
    rsp        = '0;
    cnt        = {1'b0, req.byte_count};
    wr_advance = 1'b0;

    case (req.req_type)
      i2cseq_pkg::REQ_WRITE, i2cseq_pkg::REQ_READ: begin
        if (cnt > 9'(i2cseq_pkg::MaxBytes)) begin
          cnt = 9'(i2cseq_pkg::MaxBytes);
        end
        if (req.req_type[0] && cnt == 9'd0) begin
          cnt = 9'd1;
        end
        state_nxt.reading        = req.req_type[0];
        state_nxt.target_address = req.slave_address;
        state_nxt.bytes_left     = cnt[7:0];
        state_nxt.phase          = i2cseq_pkg::PH_START;
        rsp.command              = i2cseq_pkg::CMD_START;
      end
      i2cseq_pkg::REQ_STEP: begin
        unique case (state.phase)
          i2cseq_pkg::PH_IDLE: begin
          end
          i2cseq_pkg::PH_START: begin
            if (code == i2cseq_pkg::StStart || code == i2cseq_pkg::StRepStart) begin
              state_nxt.phase = i2cseq_pkg::PH_ADDR;
              rsp.command     = i2cseq_pkg::CMD_SEND;
              rsp.tx_value    = {state.target_address, state.reading};
            end else begin
              state_nxt.phase  = i2cseq_pkg::PH_IDLE;
              rsp.outcome      = i2cseq_pkg::OUT_FAIL;
              rsp.error_status = code;
            end
          end
          i2cseq_pkg::PH_ADDR: begin
            if (code != (state.reading ? i2cseq_pkg::StAddrAckRd
                                       : i2cseq_pkg::StAddrAckWr)) begin
              state_nxt.phase  = i2cseq_pkg::PH_IDLE;
              rsp.outcome      = i2cseq_pkg::OUT_FAIL;
              rsp.error_status = code;
            end else if (state.reading) begin
              if (state.bytes_left > 8'd1) begin
                state_nxt.phase = i2cseq_pkg::PH_RX_ACK;
                rsp.command     = i2cseq_pkg::CMD_RACK;
              end else begin
                state_nxt.phase = i2cseq_pkg::PH_RX_NACK;
                rsp.command     = i2cseq_pkg::CMD_RNACK;
              end
            end else begin
              wr_advance = 1'b1;
            end
          end
          i2cseq_pkg::PH_WDATA: begin
            if (code == i2cseq_pkg::StDataAckWr) begin
              wr_advance = 1'b1;
            end else begin
              state_nxt.phase  = i2cseq_pkg::PH_IDLE;
              rsp.outcome      = i2cseq_pkg::OUT_FAIL;
              rsp.error_status = code;
            end
          end
          i2cseq_pkg::PH_RX_ACK: begin
            if (code == i2cseq_pkg::StDataAckRd) begin
              state_nxt.bytes_left = state.bytes_left - 8'd1;
              rsp.rx_valid         = 1'b1;
              rsp.rx_data          = req.rx_byte;
              if (state.bytes_left > 8'd2) begin
                rsp.command = i2cseq_pkg::CMD_RACK;
              end else begin
                state_nxt.phase = i2cseq_pkg::PH_RX_NACK;
                rsp.command     = i2cseq_pkg::CMD_RNACK;
              end
            end else begin
              state_nxt.phase  = i2cseq_pkg::PH_IDLE;
              rsp.outcome      = i2cseq_pkg::OUT_FAIL;
              rsp.error_status = code;
            end
          end
          i2cseq_pkg::PH_RX_NACK: begin
            if (code == i2cseq_pkg::StDataNackRd) begin
              state_nxt.bytes_left = 8'd0;
              state_nxt.phase      = i2cseq_pkg::PH_IDLE;
              rsp.command          = i2cseq_pkg::CMD_STOP;
              rsp.rx_valid         = 1'b1;
              rsp.rx_data          = req.rx_byte;
              rsp.outcome          = i2cseq_pkg::OUT_DONE;
            end else begin
              state_nxt.phase  = i2cseq_pkg::PH_IDLE;
              rsp.outcome      = i2cseq_pkg::OUT_FAIL;
              rsp.error_status = code;
            end
          end
          default: begin
            state_nxt.phase = i2cseq_pkg::PH_IDLE;
          end
        endcase

        if (wr_advance) begin
          if (state.bytes_left == 8'd0) begin
            state_nxt.phase = i2cseq_pkg::PH_IDLE;
            rsp.command     = i2cseq_pkg::CMD_STOP;
            rsp.outcome     = i2cseq_pkg::OUT_DONE;
          end else begin
            state_nxt.bytes_left = state.bytes_left - 8'd1;
            state_nxt.phase      = i2cseq_pkg::PH_WDATA;
            rsp.command          = i2cseq_pkg::CMD_SEND;
            rsp.tx_value         = req.tx_byte;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master transaction sequencer. A queue of
// request beats (directed corner cases, then mostly well-formed write and
// read transactions with random content, broken and abandoned ones mixed in)
// feeds a clocked driver. Each accepted beat runs through a local model of
// the sequencer, and a clocked monitor compares every result beat field by
// field with the oldest predicted command. Both channels idle in bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cseq_pkg::*;

  localparam logic [1:0] ReqUndefined = 2'd3;

  typedef struct {
    req_t beat;
    bit   drain;
  } stim_beat_t;

  logic clk;
  logic rst_n;

  i2cseq_req_if req_ch ();
  i2cseq_rsp_if rsp_ch ();

  i2c_master_transaction_sequencer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  stim_beat_t stim_q[$];
  rsp_t       pending_cmds[$];
  req_t       cur_req;
  int         noise_beats = 0;
  int         mismatches  = 0;
  int         in_gap      = 0;
  int         out_stall   = 0;

  phase_t     seq_phase   = PH_IDLE;
  logic       seq_reading = 1'b0;
  logic [6:0] seq_addr    = 7'd0;
  logic [7:0] seq_left    = 8'd0;

  function automatic rsp_t plan_bus_command(req_t r);
    rsp_t       o;
    logic [7:0] code;
    logic [7:0] cnt;
    bit         bad;
    bit         write_next;
    o = '0;
    bad = 1'b0;
    write_next = 1'b0;
    code = r.bus_status & StatusMask;
    if (r.req_type == REQ_WRITE || r.req_type == REQ_READ) begin
      cnt = r.byte_count;
      if (int'(cnt) > MaxBytes) cnt = 8'(MaxBytes);
      seq_reading = (r.req_type == REQ_READ);
      if (seq_reading && cnt == 8'd0) cnt = 8'd1;
      seq_addr = r.slave_address;
      seq_left = cnt;
      seq_phase = PH_START;
      o.command = CMD_START;
      return o;
    end
    if (r.req_type != REQ_STEP || seq_phase == PH_IDLE) return o;
    case (seq_phase)
      PH_START: begin
        if (code != StStart && code != StRepStart) begin
          bad = 1'b1;
        end else begin
          seq_phase = PH_ADDR;
          o.command = CMD_SEND;
          o.tx_value = {seq_addr, seq_reading};
        end
      end
      PH_ADDR: begin
        if (code != (seq_reading ? StAddrAckRd : StAddrAckWr)) begin
          bad = 1'b1;
        end else if (seq_reading) begin
          if (seq_left > 8'd1) begin
            seq_phase = PH_RX_ACK;
            o.command = CMD_RACK;
          end else begin
            seq_phase = PH_RX_NACK;
            o.command = CMD_RNACK;
          end
        end else begin
          write_next = 1'b1;
        end
      end
      PH_WDATA: begin
        if (code != StDataAckWr) bad = 1'b1;
        else write_next = 1'b1;
      end
      PH_RX_ACK: begin
        if (code != StDataAckRd) begin
          bad = 1'b1;
        end else begin
          seq_left = seq_left - 8'd1;
          o.rx_valid = 1'b1;
          o.rx_data = r.rx_byte;
          if (seq_left > 8'd1) begin
            o.command = CMD_RACK;
          end else begin
            seq_phase = PH_RX_NACK;
            o.command = CMD_RNACK;
          end
        end
      end
      PH_RX_NACK: begin
        if (code != StDataNackRd) begin
          bad = 1'b1;
        end else begin
          seq_left = 8'd0;
          seq_phase = PH_IDLE;
          o.command = CMD_STOP;
          o.rx_valid = 1'b1;
          o.rx_data = r.rx_byte;
          o.outcome = OUT_DONE;
        end
      end
      default: begin
        seq_phase = PH_IDLE;
      end
    endcase
    if (bad) begin
      seq_phase = PH_IDLE;
      o = '0;
      o.outcome = OUT_FAIL;
      o.error_status = code;
    end else if (write_next) begin
      if (seq_left == 8'd0) begin
        seq_phase = PH_IDLE;
        o.command = CMD_STOP;
        o.outcome = OUT_DONE;
      end else begin
        seq_left = seq_left - 8'd1;
        seq_phase = PH_WDATA;
        o.command = CMD_SEND;
        o.tx_value = r.tx_byte;
      end
    end
    return o;
  endfunction

  function automatic bit idling_allowed();
    return stim_q.size() >= 80 && (stim_q.size() / 60) % 3 != 0;
  endfunction

  task automatic add_beat(logic [1:0] rq, logic [6:0] addr, logic [7:0] cnt,
                          logic [7:0] status, bit drain);
    stim_beat_t s;
    s.beat.req_type      = rq;
    s.beat.slave_address = addr;
    s.beat.byte_count    = cnt;
    s.beat.bus_status    = status;
    s.beat.rx_byte       = 8'($urandom);
    s.beat.tx_byte       = 8'($urandom);
    s.drain              = drain;
    stim_q.push_back(s);
  endtask

  task automatic add_transaction(bit drain);
    bit         rd;
    logic [7:0] cnt;
    int         eff;
    int         stop_at;
    logic [7:0] codes[$];
    rd = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 7) == 0) cnt = 8'($urandom_range(0, 255));
    else cnt = 8'($urandom_range(0, 6));
    eff = (rd && cnt == 8'd0) ? 1 : int'(cnt);
    codes.push_back($urandom_range(0, 1) ? StStart : StRepStart);
    codes.push_back(rd ? StAddrAckRd : StAddrAckWr);
    for (int i = 0; i < eff; i++) begin
      if (rd) codes.push_back((i == eff - 1) ? StDataNackRd : StDataAckRd);
      else codes.push_back(StDataAckWr);
    end
    stop_at = codes.size();
    if (eff > 12 || $urandom_range(0, 3) == 0)
      stop_at = $urandom_range(0, (codes.size() < 10) ? codes.size() - 1 : 9);
    add_beat(rd ? REQ_READ : REQ_WRITE, 7'($urandom), cnt, 8'($urandom), drain);
    for (int i = 0; i < stop_at; i++)
      add_beat(REQ_STEP, 7'($urandom), 8'($urandom),
               codes[i] | 8'($urandom_range(0, 7)), 1'b0);
    // break with a bad status, or leave it for the next begin to abandon
    if (stop_at < codes.size() && $urandom_range(0, 1) == 1)
      add_beat(REQ_STEP, 7'($urandom), 8'($urandom), 8'($urandom), 1'b0);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    stim_beat_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) pending_cmds.push_back(plan_bus_command(cur_req));
      if (!req_ch.valid || req_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          req_ch.valid <= 1'b0;
        end else if (stim_q.size() == 0 || (stim_q[0].drain && pending_cmds.size() != 0)) begin
          req_ch.valid <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 7) - 1;
          req_ch.valid <= 1'b0;
        end else begin
          nxt = stim_q.pop_front();
          cur_req = nxt.beat;
          req_ch.valid         <= 1'b1;
          req_ch.req_type      <= nxt.beat.req_type;
          req_ch.slave_address <= nxt.beat.slave_address;
          req_ch.byte_count    <= nxt.beat.byte_count;
          req_ch.bus_status    <= nxt.beat.bus_status;
          req_ch.rx_byte       <= nxt.beat.rx_byte;
          req_ch.tx_byte       <= nxt.beat.tx_byte;
        end
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, actual 0x%02h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_cmds.size() == 0) begin
          $error("result beat with no command pending: command %0d", rsp_ch.command);
          mismatches++;
        end else begin
          want = pending_cmds.pop_front();
          check_field("command", 8'(want.command), 8'(rsp_ch.command));
          check_field("tx_value", want.tx_value, rsp_ch.tx_value);
          check_field("rx_valid", 8'(want.rx_valid), 8'(rsp_ch.rx_valid));
          check_field("rx_data", want.rx_data, rsp_ch.rx_data);
          check_field("outcome", 8'(want.outcome), 8'(rsp_ch.outcome));
          check_field("error_status", want.error_status, rsp_ch.error_status);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        rsp_ch.ready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(1, 7) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int directed;
    rst_n = 1'b0;

    // step while idle, undefined request
    add_beat(REQ_STEP, 7'h7F, 8'hFF, StStart, 1'b0);
    add_beat(ReqUndefined, 7'h00, 8'h00, 8'hFF, 1'b0);
    // zero-length write
    add_beat(REQ_WRITE, 7'h7F, 8'h00, 8'h00, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StStart, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StAddrAckWr | 8'h07, 1'b0);
    // zero-length read becomes one byte
    add_beat(REQ_READ, 7'h00, 8'h00, 8'h00, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StRepStart | 8'h01, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StAddrAckRd, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StDataNackRd, 1'b0);
    // two-byte write
    add_beat(REQ_WRITE, 7'h2A, 8'h02, 8'h00, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StStart, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StAddrAckWr, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StDataAckWr, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StDataAckWr | 8'h07, 1'b0);
    // three-byte read
    add_beat(REQ_READ, 7'h55, 8'h03, 8'h00, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StStart, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StAddrAckRd, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StDataAckRd, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StDataAckRd | 8'h07, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StDataNackRd, 1'b0);
    // abandon a busy write with a new begin, then fail on a bad status
    add_beat(REQ_WRITE, 7'h7F, 8'hFF, 8'h00, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, StStart, 1'b0);
    add_beat(REQ_READ, 7'h01, 8'h01, 8'h00, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, 8'hFF, 1'b0);
    // failure on an all-zero status
    add_beat(REQ_WRITE, 7'h40, 8'h80, 8'h00, 1'b0);
    add_beat(REQ_STEP, 7'h00, 8'h00, 8'h00, 1'b0);
    directed = stim_q.size();

    add_transaction(1'b1);
    while (stim_q.size() - noise_beats < directed + 650) begin
      if ($urandom_range(0, 9) == 0) begin
        add_beat($urandom_range(0, 1) ? REQ_STEP : ReqUndefined, 7'($urandom),
                 8'($urandom), 8'($urandom), 1'b0);
        noise_beats++;
      end
      add_transaction($urandom_range(0, 49) == 0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || req_ch.valid) @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
